[sv/gttc_pkg.sv]
// ----------------------------------------------------------------------------
// gttc_pkg
// Shared types, constants and helpers of the thrust and torque controller.
// ----------------------------------------------------------------------------
package gttc_pkg;

    localparam int IN_W        = 480;
    localparam int OUT_W       = 96;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int SQRT_STEPS   = 30;
    localparam int CORDIC_STEPS = 28;
    localparam int DIV_STEPS    = 31;
    localparam int BACK_STAGES  = 1 + SQRT_STEPS + CORDIC_STEPS + 1 + DIV_STEPS + 2;

    localparam logic [29:0] THETA_MIN_Q28 = 30'd268;
    localparam logic [29:0] PI_Q28        = 30'd843314857;
    localparam logic [29:0] HALF_PI_Q28   = 30'd421657429;

    localparam logic [27:0] ATAN_Q28 [CORDIC_STEPS] = '{
        28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290, 28'd16755422,
        28'd8385879, 28'd4193963, 28'd2097109, 28'd1048571, 28'd524287,
        28'd262144, 28'd131072, 28'd65536, 28'd32768, 28'd16384, 28'd8192,
        28'd4096, 28'd2048, 28'd1024, 28'd512, 28'd256, 28'd128, 28'd64,
        28'd32, 28'd16, 28'd8, 28'd4, 28'd2
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_GAIN  = 3'd0,
        CFG_VEL_GAIN  = 3'd1,
        CFG_ATT_GAIN  = 3'd2,
        CFG_RATE_GAIN = 3'd3,
        CFG_INERTIA   = 3'd4,
        CFG_WEIGHT    = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [47:0] pos_gain;
        logic [47:0] vel_gain;
        logic [47:0] att_gain;
        logic [47:0] rate_gain;
        logic [47:0] inertia;
        logic [15:0] weight;
    } gains_t;

    typedef struct packed {
        logic signed [30:0] cos_v;
        logic [2:0][19:0]   diff;
        logic [47:0]        thrust;
        logic [47:0]        rate;
    } q_item_t;

    function automatic logic [15:0] sat16(input logic signed [52:0] v);
        logic [15:0] r;
        if (v < -53'sd32768)
        begin
            r = 16'h8000;
        end
        else if (v > 53'sd32767)
        begin
            r = 16'h7fff;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

[sv/gttc_front.sv]
// ----------------------------------------------------------------------------
// gttc_front
// Accepts requests; forms the body force, attitude error matrix and cosine.
// ----------------------------------------------------------------------------
module gttc_front
    import gttc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [IN_W-1:0] in_data,
    input  gains_t          gains,
    output logic            out_valid,
    output q_item_t         out_item,
    input  logic            out_room
);

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [15:0] rm   [3][3];
    logic signed [15:0] rd   [3][3];
    logic signed [16:0] perr [3];
    logic signed [15:0] vel  [3];
    logic signed [34:0] wt;
    logic signed [34:0] dif  [3];
    logic signed [34:0] dsh  [3];
    logic signed [52:0] acc  [3];
    logic signed [36:0] cm;

    logic signed [32:0] pos1_reg  [3];
    logic signed [31:0] vel1_reg  [3];
    logic signed [31:0] prod1_reg [3][3][3];
    logic signed [15:0] rm1_reg   [3][3];
    logic signed [15:0] rm2_reg   [3][3];
    logic [47:0]        rate1_reg, rate2_reg, rate3_reg, rate4_reg;
    logic signed [34:0] r2_reg    [3];
    logic signed [33:0] psi2_reg  [3][3];
    logic signed [50:0] fp3_reg   [3][3];
    logic signed [35:0] trace3_reg;
    logic [19:0]        d3_reg    [3];
    logic [47:0]        thrust4_reg;
    logic signed [30:0] cos4_reg;
    logic [2:0][19:0]   d4_reg;

    assign en        = !(v4_reg && !out_room);
    assign in_ready  = en;
    assign out_valid = v4_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            perr[i] = $signed(in_data[16*i +: 16]) - $signed(in_data[48 + 16*i +: 16]);
            vel[i]  = $signed(in_data[96 + 16*i +: 16]);
            for (int c = 0; c < 3; c++)
            begin
                rm[i][c] = $signed(in_data[192 + 48*i + 16*c +: 16]);
                rd[i][c] = $signed(in_data[336 + 48*i + 16*c +: 16]);
            end
        end
        wt = {{11{gains.weight[15]}}, gains.weight, 8'd0};
        dif[0] = psi2_reg[2][1] - psi2_reg[1][2];
        dif[1] = psi2_reg[0][2] - psi2_reg[2][0];
        dif[2] = psi2_reg[1][0] - psi2_reg[0][1];
        for (int i = 0; i < 3; i++)
        begin
            dsh[i] = dif[i] >>> 14;
            acc[i] = fp3_reg[i][0] + fp3_reg[i][1] + fp3_reg[i][2];
        end
        cm = trace3_reg - 37'sd268435456;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos1_reg[i] <= $signed(gains.pos_gain[16*i +: 16]) * perr[i];
                vel1_reg[i] <= $signed(gains.vel_gain[16*i +: 16]) * vel[i];
                for (int k = 0; k < 3; k++)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        prod1_reg[i][k][j] <= rm[j][i] * rd[j][k];
                    end
                end
            end
            rm1_reg   <= rm;
            rate1_reg <= in_data[191:144];

            for (int i = 0; i < 3; i++)
            begin
                r2_reg[i] <= pos1_reg[i] + vel1_reg[i] + ((i == 2) ? wt : 35'sd0);
                for (int k = 0; k < 3; k++)
                begin
                    psi2_reg[i][k] <= prod1_reg[i][k][0] + prod1_reg[i][k][1]
                                    + prod1_reg[i][k][2];
                end
            end
            rm2_reg   <= rm1_reg;
            rate2_reg <= rate1_reg;

            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    fp3_reg[i][j] <= rm2_reg[j][i] * r2_reg[j];
                end
                d3_reg[i] <= dsh[i][19:0];
            end
            trace3_reg <= psi2_reg[0][0] + psi2_reg[1][1] + psi2_reg[2][2];
            rate3_reg  <= rate2_reg;

            for (int i = 0; i < 3; i++)
            begin
                thrust4_reg[16*i +: 16] <= sat16(acc[i] >>> 26);
                d4_reg[i]               <= d3_reg[i];
            end
            if (cm > 37'sd536870912)
            begin
                cos4_reg <= 31'sd536870912;
            end
            else if (cm < -37'sd536870912)
            begin
                cos4_reg <= -31'sd536870912;
            end
            else
            begin
                cos4_reg <= cm[30:0];
            end
            rate4_reg <= rate3_reg;
        end
    end

    always_comb
    begin
        out_item.cos_v  = cos4_reg;
        out_item.diff   = d4_reg;
        out_item.thrust = thrust4_reg;
        out_item.rate   = rate4_reg;
    end

endmodule

[sv/gttc_queue.sv]
// ----------------------------------------------------------------------------
// gttc_queue
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module gttc_queue
    import gttc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    input  q_item_t push_item,
    output logic    push_room,
    input  logic    pop,
    output logic    pop_valid,
    output q_item_t pop_item
);

    q_item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_reg, rd_reg;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                push;

    assign push_room = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH)) || pop;
    assign push      = push_valid && push_room;
    assign pop_valid = count_reg != '0;
    assign pop_item  = mem[rd_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_item;
        end
    end

endmodule

[sv/gttc_back.sv]
// ----------------------------------------------------------------------------
// gttc_back
// Sine, angle, rotation error division and torque; holds the result register.
// ----------------------------------------------------------------------------
module gttc_back
    import gttc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  q_item_t          in_item,
    output logic             pop,
    input  gains_t           gains,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_data
);

    logic                    en;
    logic [BACK_STAGES-1:0]  vld_reg;
    logic                    out_valid_reg;
    logic [OUT_W-1:0]        out_data_reg;

    // square root
    logic signed [61:0] cc;
    logic [59:0]        sv_reg  [SQRT_STEPS+1];
    logic [59:0]        sr_reg  [SQRT_STEPS+1];
    q_item_t            sit_reg [SQRT_STEPS+1];

    // angle
    logic signed [33:0] cx_reg  [CORDIC_STEPS];
    logic signed [33:0] cy_reg  [CORDIC_STEPS];
    logic signed [32:0] cz_reg  [CORDIC_STEPS];
    logic [29:0]        cs_reg  [CORDIC_STEPS];
    q_item_t            cit_reg [CORDIC_STEPS];
    logic [29:0]        theta;

    // numerator and divisor
    logic signed [50:0] mnum_reg [3];
    logic [30:0]        mden_reg;
    logic               mzero_reg;
    q_item_t            mit_reg;

    // division
    logic [30:0]        drem_reg  [DIV_STEPS][3];
    logic [30:0]        dq_reg    [DIV_STEPS][3];
    logic [30:0]        dlow_reg  [DIV_STEPS][3];
    logic               dneg_reg  [DIV_STEPS][3];
    logic               dovf_reg  [DIV_STEPS][3];
    logic [30:0]        dden_reg  [DIV_STEPS];
    logic               dzero_reg [DIV_STEPS];
    q_item_t            dit_reg   [DIV_STEPS];
    logic signed [31:0] er [3];

    // torque
    logic signed [47:0] ke_reg [3];
    logic signed [31:0] kw_reg [3];
    logic signed [39:0] hi_reg [3];
    logic signed [41:0] lo_reg [3];
    logic [47:0]        thrust1_reg, thrust2_reg;
    logic signed [48:0] tt  [3];
    logic signed [48:0] tsh [3];
    logic signed [52:0] tq  [3];

    assign en        = !out_valid_reg || out_ready;
    assign pop       = en && in_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[BACK_STAGES-2:0], in_valid};
            out_valid_reg <= vld_reg[BACK_STAGES-1];
        end
    end

    assign cc = $signed(in_item.cos_v) * $signed(in_item.cos_v);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sv_reg[0]  <= (60'd1 << 58) - 60'(cc);
            sr_reg[0]  <= '0;
            sit_reg[0] <= in_item;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        logic [59:0] bitv;
        logic [59:0] trial;
        assign bitv  = 60'd1 << (58 - 2 * k);
        assign trial = sr_reg[k] + bitv;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sv_reg[k] >= trial)
                begin
                    sv_reg[k+1] <= sv_reg[k] - trial;
                    sr_reg[k+1] <= (sr_reg[k] >> 1) + bitv;
                end
                else
                begin
                    sv_reg[k+1] <= sv_reg[k];
                    sr_reg[k+1] <= sr_reg[k] >> 1;
                end
                sit_reg[k+1] <= sit_reg[k];
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        logic signed [33:0] xin, yin;
        logic signed [32:0] zin;
        logic [29:0]        sin_v;
        q_item_t            itin;
        if (i == 0)
        begin : g_init
            always_comb
            begin
                sin_v = sr_reg[SQRT_STEPS][29:0];
                itin  = sit_reg[SQRT_STEPS];
                if (!itin.cos_v[30])
                begin
                    xin = $signed(itin.cos_v);
                    yin = $signed({4'd0, sin_v});
                    zin = '0;
                end
                else
                begin
                    xin = $signed({4'd0, sin_v});
                    yin = -$signed(itin.cos_v);
                    zin = $signed({3'd0, HALF_PI_Q28});
                end
            end
        end
        else
        begin : g_link
            assign xin   = cx_reg[i-1];
            assign yin   = cy_reg[i-1];
            assign zin   = cz_reg[i-1];
            assign sin_v = cs_reg[i-1];
            assign itin  = cit_reg[i-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (yin > 34'sd0)
                begin
                    cx_reg[i] <= xin + (yin >>> i);
                    cy_reg[i] <= yin - (xin >>> i);
                    cz_reg[i] <= zin + $signed({5'd0, ATAN_Q28[i]});
                end
                else
                begin
                    cx_reg[i] <= xin - (yin >>> i);
                    cy_reg[i] <= yin + (xin >>> i);
                    cz_reg[i] <= zin - $signed({5'd0, ATAN_Q28[i]});
                end
                cs_reg[i]  <= sin_v;
                cit_reg[i] <= itin;
            end
        end
    end

    always_comb
    begin
        if (cz_reg[CORDIC_STEPS-1] < 33'sd0)
        begin
            theta = '0;
        end
        else if (cz_reg[CORDIC_STEPS-1] > $signed({3'd0, PI_Q28}))
        begin
            theta = PI_Q28;
        end
        else
        begin
            theta = cz_reg[CORDIC_STEPS-1][29:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mnum_reg[i] <= $signed({1'b0, theta})
                             * $signed(cit_reg[CORDIC_STEPS-1].diff[i]);
            end
            mden_reg  <= {cs_reg[CORDIC_STEPS-1], 1'b0};
            mzero_reg <= (theta < THETA_MIN_Q28) || (cs_reg[CORDIC_STEPS-1] == '0);
            mit_reg   <= cit_reg[CORDIC_STEPS-1];
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [30:0] rem_in  [3];
        logic [30:0] q_in    [3];
        logic [30:0] low_in  [3];
        logic        neg_in  [3];
        logic        ovf_in  [3];
        logic [31:0] tr      [3];
        logic [30:0] den_in;
        logic        zero_in;
        q_item_t     it_in;
        if (j == 0)
        begin : g_init
            logic [50:0] mag [3];
            always_comb
            begin
                den_in  = mden_reg;
                zero_in = mzero_reg;
                it_in   = mit_reg;
                for (int l = 0; l < 3; l++)
                begin
                    neg_in[l] = mnum_reg[l][50];
                    mag[l]    = neg_in[l] ? 51'(-mnum_reg[l]) : 51'(mnum_reg[l]);
                    rem_in[l] = {12'd0, mag[l][49:31]};
                    low_in[l] = mag[l][30:0];
                    q_in[l]   = '0;
                    ovf_in[l] = {12'd0, mag[l][49:31]} >= mden_reg;
                end
            end
        end
        else
        begin : g_link
            always_comb
            begin
                den_in  = dden_reg[j-1];
                zero_in = dzero_reg[j-1];
                it_in   = dit_reg[j-1];
                for (int l = 0; l < 3; l++)
                begin
                    rem_in[l] = drem_reg[j-1][l];
                    low_in[l] = dlow_reg[j-1][l];
                    q_in[l]   = dq_reg[j-1][l];
                    neg_in[l] = dneg_reg[j-1][l];
                    ovf_in[l] = dovf_reg[j-1][l];
                end
            end
        end
        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                tr[l] = {rem_in[l], low_in[l][DIV_STEPS-1-j]};
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    if (tr[l] >= {1'b0, den_in})
                    begin
                        drem_reg[j][l] <= 31'(tr[l] - {1'b0, den_in});
                        dq_reg[j][l]   <= {q_in[l][29:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg[j][l] <= tr[l][30:0];
                        dq_reg[j][l]   <= {q_in[l][29:0], 1'b0};
                    end
                    dlow_reg[j][l] <= low_in[l];
                    dneg_reg[j][l] <= neg_in[l];
                    dovf_reg[j][l] <= ovf_in[l];
                end
                dden_reg[j]  <= den_in;
                dzero_reg[j] <= zero_in;
                dit_reg[j]   <= it_in;
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (dzero_reg[DIV_STEPS-1])
            begin
                er[l] = '0;
            end
            else if (dovf_reg[DIV_STEPS-1][l])
            begin
                er[l] = dneg_reg[DIV_STEPS-1][l] ? 32'sh80000000 : 32'sh7fffffff;
            end
            else if (dneg_reg[DIV_STEPS-1][l])
            begin
                er[l] = -$signed({1'b0, dq_reg[DIV_STEPS-1][l]});
            end
            else
            begin
                er[l] = $signed({1'b0, dq_reg[DIV_STEPS-1][l]});
            end
            tt[l]  = ke_reg[l] - (49'(kw_reg[l]) <<< 5);
            tsh[l] = tt[l] >>> 25;
            tq[l]  = hi_reg[l] + (lo_reg[l] >>> 25);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                ke_reg[l] <= $signed(gains.att_gain[16*l +: 16]) * er[l];
                kw_reg[l] <= $signed(gains.rate_gain[16*l +: 16])
                           * $signed(dit_reg[DIV_STEPS-1].rate[16*l +: 16]);
                hi_reg[l] <= $signed(gains.inertia[16*l +: 16]) * $signed(tsh[l][23:0]);
                lo_reg[l] <= $signed(gains.inertia[16*l +: 16])
                           * $signed({1'b0, tt[l][24:0]});
                out_data_reg[16*l +: 16]      <= thrust2_reg[16*l +: 16];
                out_data_reg[48 + 16*l +: 16] <= sat16(tq[l]);
            end
            thrust1_reg <= dit_reg[DIV_STEPS-1].thrust;
            thrust2_reg <= thrust1_reg;
        end
    end

endmodule

[sv/geometric_thrust_torque_controller.sv]
// ----------------------------------------------------------------------------
// geometric_thrust_torque_controller
// Throughput: one request per cycle when the output is not stalled, set by the fully pipelined square root,
// angle and division stages.
// Reset: asynchronous, active low; clears all gains and empties the pipeline.
// ----------------------------------------------------------------------------
module geometric_thrust_torque_controller
    import gttc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // meas_position, target_position, meas_velocity, meas_rate,
    // attitude_row0..2, desired_row0..2 (48 bits each, low bits first)
    input  logic [IN_W-1:0]      s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // thrust_x, thrust_y, thrust_z, torque_x, torque_y, torque_z (16 bits each)
    output logic [OUT_W-1:0]     m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [47:0]          cfg_data
);

    gains_t  gains_reg;
    logic    f_valid;
    q_item_t f_item;
    logic    q_room;
    logic    q_valid;
    q_item_t q_item;
    logic    q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_POS_GAIN:  gains_reg.pos_gain  <= cfg_data;
                CFG_VEL_GAIN:  gains_reg.vel_gain  <= cfg_data;
                CFG_ATT_GAIN:  gains_reg.att_gain  <= cfg_data;
                CFG_RATE_GAIN: gains_reg.rate_gain <= cfg_data;
                CFG_INERTIA:   gains_reg.inertia   <= cfg_data;
                CFG_WEIGHT:    gains_reg.weight    <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    gttc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .gains     (gains_reg),
        .out_valid (f_valid),
        .out_item  (f_item),
        .out_room  (q_room)
    );

    gttc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_item  (f_item),
        .push_room  (q_room),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (q_item)
    );

    gttc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_item   (q_item),
        .pop       (q_pop),
        .gains     (gains_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

[sv/gttc_checker.sv]
// ----------------------------------------------------------------------------
// gttc_checker
// Port-level checks of the thrust and torque controller.
// ----------------------------------------------------------------------------
module gttc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output drains");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write refused");

endmodule

bind geometric_thrust_torque_controller gttc_checker u_gttc_checker (.*);
